>>> rtl/bvc_pkg.sv
// Package for the boosted vote combiner: widths, constants and divider control types.
package bvc_pkg;

   localparam int WEIGHT_W   = 16;
   localparam int SUM_W      = 26;
   localparam int TOTAL_W    = SUM_W + 1;
   localparam int SHARE_FRAC = 16;
   localparam int SHARE_W    = SHARE_FRAC + 1;
   localparam int DIV_CNT_W  = $clog2(SHARE_W);

   localparam logic [TOTAL_W-1:0] SUM_MAX = TOTAL_W'((64'd1 << SUM_W) - 64'd1);

   // sequencer to divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // divider to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> rtl/bvc_req_if.sv
// Request channel: one weak learner vote per transfer.
interface bvc_req_if
   import bvc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                learner_class;
   logic [WEIGHT_W-1:0] learner_weight;
   logic                last_learner;

   modport source (output valid, output learner_class, output learner_weight,
                   output last_learner, input ready);
   modport sink   (input valid, input learner_class, input learner_weight,
                   input last_learner, output ready);
endinterface

>>> rtl/bvc_rsp_if.sv
// Response channel: vote sums, winner and shares of one example per transfer.
interface bvc_rsp_if
   import bvc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [SUM_W-1:0]   votes_class0;
   logic [SUM_W-1:0]   votes_class1;
   logic               chosen_class;
   logic [SHARE_W-1:0] share_class0;
   logic [SHARE_W-1:0] share_class1;
   logic               zero_total;

   modport source (output valid, output votes_class0, output votes_class1,
                   output chosen_class, output share_class0, output share_class1,
                   output zero_total, input ready);
   modport sink   (input valid, input votes_class0, input votes_class1,
                   input chosen_class, input share_class0, input share_class1,
                   input zero_total, output ready);
endinterface

>>> rtl/bvc_divider.sv
// Restoring divider, one quotient bit per cycle: floor(part * 2^16 / total), part <= total.
module bvc_divider
   import bvc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctrl_type       ctrl,
   input  logic [SUM_W-1:0]   part,
   input  logic [TOTAL_W-1:0] total,
   output div_stat_type       stat,
   output logic [SHARE_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOTAL_W:0]     rem_ff, rem_in;
   logic [SHARE_W-1:0]   quo_ff, quo_in;

   logic [TOTAL_W:0]     divisor;
   logic                 q_bit;
   logic [TOTAL_W:0]     rem_next;

   assign divisor  = {1'b0, total};
   assign q_bit    = (rem_ff >= divisor);
   assign rem_next = q_bit ? (rem_ff - divisor) : rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = (TOTAL_W + 1)'(part);
         quo_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SHARE_W-2:0], q_bit};
         // remainder stays below total, so the doubled value fits
         rem_in = {rem_next[TOTAL_W-1:0], 1'b0};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(SHARE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> rtl/boosted_vote_combiner.sv
// Boosted vote combiner top level: vote accumulation, share sequencer and result register.
//
// Usage:
//  - req_ch carries one weak learner vote per transfer: learner_class, its Q8.8
//    learner_weight and last_learner, which closes the run of one example.
//  - Each vote is added to its class sum; sums saturate at 2^26-1.
//    A run of votes is taken at one transfer per cycle.
//  - On the last vote, rsp_ch gets one transfer with both sums, the winning class
//    (ties go to class 0) and each class's share of the total in Q1.16.
//  - Shares come from one shared restoring divider run twice, 17 steps each.
//    After the last vote req_ch.ready stays low through both divisions with a nonzero
//    total; with a zero total no division runs (shares 0, zero_total set).
//  - Throughput: one vote per cycle within a run; between examples req_ch.ready
//    is low while the shares are divided.
//  - The result sits in an output register; votes of the next example are
//    taken while it waits. If the receiver still stalls when the next example
//    finishes dividing, the block holds with req_ch.ready low until the
//    pending transfer completes.
//  - Synchronous active-high reset clears both sums, the sequencer and
//    rsp_ch.valid.
module boosted_vote_combiner
   import bvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   bvc_req_if.sink      req_ch,
   bvc_rsp_if.source    rsp_ch
);

   typedef enum logic [5:0] {
      ST_ACCUM  = 6'b000001,
      ST_LOAD0  = 6'b000010,
      ST_WAIT0  = 6'b000100,
      ST_LOAD1  = 6'b001000,
      ST_WAIT1  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // running sums of the current example
   logic [SUM_W-1:0]   sum0_ff, sum0_in;
   logic [SUM_W-1:0]   sum1_ff, sum1_in;
   // final sums of the example being divided
   logic [SUM_W-1:0]   vote0_ff, vote0_in;
   logic [SUM_W-1:0]   vote1_ff, vote1_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [SHARE_W-1:0] share0_ff, share0_in;
   logic [SHARE_W-1:0] share1_ff, share1_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_v0_ff, rsp_v0_in;
   logic [SUM_W-1:0]   rsp_v1_ff, rsp_v1_in;
   logic               rsp_cls_ff, rsp_cls_in;
   logic [SHARE_W-1:0] rsp_s0_ff, rsp_s0_in;
   logic [SHARE_W-1:0] rsp_s1_ff, rsp_s1_in;
   logic               rsp_zero_ff, rsp_zero_in;

   logic               req_fire;
   logic               out_free;
   logic [TOTAL_W-1:0] add_sum;
   logic [SUM_W-1:0]   add_sat;
   logic [SUM_W-1:0]   new0;
   logic [SUM_W-1:0]   new1;

   div_ctrl_type       div_ctrl;
   div_stat_type       div_stat;
   logic [SUM_W-1:0]   div_part;
   logic [SHARE_W-1:0] div_quo;

   assign req_ch.ready = (state_ff == ST_ACCUM);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // one saturating adder, steered by the vote's class
   always_comb begin
      add_sum = (req_ch.learner_class ? {1'b0, sum1_ff} : {1'b0, sum0_ff})
              + TOTAL_W'(req_ch.learner_weight);
      add_sat = (add_sum > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : add_sum[SUM_W-1:0];
      new0    = req_ch.learner_class ? sum0_ff : add_sat;
      new1    = req_ch.learner_class ? add_sat : sum1_ff;
   end

   assign div_ctrl.start = (state_ff == ST_LOAD0) || (state_ff == ST_LOAD1);
   assign div_part       = (state_ff == ST_LOAD1) ? vote1_ff : vote0_ff;

   bvc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .part     (div_part),
      .total    (total_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      sum0_in      = sum0_ff;
      sum1_in      = sum1_ff;
      vote0_in     = vote0_ff;
      vote1_in     = vote1_ff;
      total_in     = total_ff;
      share0_in    = share0_ff;
      share1_in    = share1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_v0_in    = rsp_v0_ff;
      rsp_v1_in    = rsp_v1_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_s0_in    = rsp_s0_ff;
      rsp_s1_in    = rsp_s1_ff;
      rsp_zero_in  = rsp_zero_ff;

      unique case (state_ff)
         ST_ACCUM: begin
            if (req_fire) begin
               if (req_ch.last_learner) begin
                  // last vote counts, then sums clear for the next example
                  vote0_in  = new0;
                  vote1_in  = new1;
                  total_in  = TOTAL_W'(new0) + TOTAL_W'(new1);
                  sum0_in   = '0;
                  sum1_in   = '0;
                  share0_in = '0;
                  share1_in = '0;
                  if ((new0 == '0) && (new1 == '0)) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_LOAD0;
                  end
               end else begin
                  sum0_in = new0;
                  sum1_in = new1;
               end
            end
         end
         ST_LOAD0: begin
            state_in = ST_WAIT0;
         end
         ST_WAIT0: begin
            if (div_stat.done) begin
               share0_in = div_quo;
               state_in  = ST_LOAD1;
            end
         end
         ST_LOAD1: begin
            state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            if (div_stat.done) begin
               share1_in = div_quo;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_v0_in    = vote0_ff;
               rsp_v1_in    = vote1_ff;
               rsp_cls_in   = (vote1_ff > vote0_ff);
               rsp_s0_in    = share0_ff;
               rsp_s1_in    = share1_ff;
               rsp_zero_in  = (total_ff == '0);
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         sum0_ff      <= '0;
         sum1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum0_ff      <= sum0_in;
         sum1_ff      <= sum1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vote0_ff    <= vote0_in;
      vote1_ff    <= vote1_in;
      total_ff    <= total_in;
      share0_ff   <= share0_in;
      share1_ff   <= share1_in;
      rsp_v0_ff   <= rsp_v0_in;
      rsp_v1_ff   <= rsp_v1_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_s0_ff   <= rsp_s0_in;
      rsp_s1_ff   <= rsp_s1_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.votes_class0 = rsp_v0_ff;
   assign rsp_ch.votes_class1 = rsp_v1_ff;
   assign rsp_ch.chosen_class = rsp_cls_ff;
   assign rsp_ch.share_class0 = rsp_s0_ff;
   assign rsp_ch.share_class1 = rsp_s1_ff;
   assign rsp_ch.zero_total   = rsp_zero_ff;

   // no vote is taken while the divider runs
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !req_ch.ready)
      else $error("vote taken while divider busy");

   // closing vote leaves both sums cleared
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.last_learner) |=> (sum0_ff == '0) && (sum1_ff == '0))
      else $error("sums not cleared after last vote");

   // zero total carries zero shares
   a_zero_shares: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_ff) |-> (rsp_s0_ff == '0) && (rsp_s1_ff == '0))
      else $error("nonzero share with zero total");

   // winner agrees with the sums it is sent with
   a_winner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cls_ff == (rsp_v1_ff > rsp_v0_ff)))
      else $error("chosen class disagrees with vote sums");

   // result register only reloads once the pending transfer is gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_FINISH))
      else $error("result register overwritten while stalled");

endmodule
